@@ design/swmmm_pkg.sv @@
// Shared types and constants for the sliding-window min/max/mean block.
// No dependencies; compile first.
package swmmm_pkg;

  // Fixed field widths
  localparam int SAMPLE_W  = 32;
  localparam int VAL_W     = 31;
  localparam int COUNT_W   = 10;
  localparam int WSIZE_W   = 10;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Window size after reset
  localparam logic [WSIZE_W-1:0] WINDOW_RESET = 10'd300;

  // Register index decoded from paddr[2]
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TRIM   = 7'b0000010,
    S_INSERT = 7'b0000100,
    S_LOAD   = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

endpackage

@@ design/swmmm_if.sv @@
// Valid/ready channel interfaces for sample requests and result requests.
// Depends on swmmm_pkg for field widths.
interface swmmm_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [swmmm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swmmm_result_if;
  logic                             valid;
  logic                             ready;
  logic [swmmm_pkg::COUNT_W-1:0]    held_count;
  logic [swmmm_pkg::VAL_W-1:0]      window_min;
  logic [swmmm_pkg::VAL_W-1:0]      window_max;
  logic [swmmm_pkg::VAL_W-1:0]      window_mean;
  logic                             accepted;

  modport source (output valid, output held_count, output window_min, output window_max,
                  output window_mean, output accepted, input ready);
  modport sink   (input valid, input held_count, input window_min, input window_max,
                  input window_mean, input accepted, output ready);
endinterface

@@ design/sliding_window_min_max_mean_top.sv @@
// Sliding-window min/max/mean over non-negative Q23.8 samples.
// Depends on swmmm_pkg and the channel interfaces in swmmm_if.sv.
//
// Usage:
//   sample_ch carries one signed Q23.8 sample per request. A negative
//   sample is skipped; otherwise it enters a ring of the latest
//   window_size samples. Every request yields one request on result_ch:
//   held count, min, max and truncated mean of the held samples (all
//   zero when the window is empty) and whether the sample was stored.
//   window_size is written over the APB port at byte address 0; a
//   lowered size drops the oldest excess samples before the next sample.
// Timing:
//   One request at a time: a taken sample passes through trim, insert, load,
//   a scan of one ring entry per cycle and SUM_W = 31 + clog2(MAX_WINDOW + 1)
//   restoring divider steps to done (scan and divide are skipped if the window
//   is empty); no new sample is taken until the result is loaded.
// Reset and stall:
//   rst empties the window and sets window_size to 300. The result sits in
//   an output register; a new sample is taken while it waits, and the
//   sequencer holds its next result until the receiver takes the old one.
module sliding_window_min_max_mean_top #(
  parameter int MAX_WINDOW = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  swmmm_sample_if.sink                    sample_ch,
  swmmm_result_if.source                  result_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swmmm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [swmmm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [swmmm_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import swmmm_pkg::*;

  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int ADD_W  = CNT_W + 1;
  localparam int SUM_W  = VAL_W + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam logic [ADD_W-1:0] MAXW      = ADD_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(MAX_WINDOW);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_WINDOW - 1);

  // Clamp a written window size to the ring depth
  function automatic logic [CNT_W-1:0] eff_size(input logic [WSIZE_W-1:0] w);
    if (32'(w) > MAX_WINDOW) begin
      return CAP_MAX;
    end
    return CNT_W'(w);
  endfunction

  // Ring index of a sum below twice the depth
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [ADD_W-1:0] a);
    if (a >= MAXW) begin
      return IDX_W'(a - MAXW);
    end
    return IDX_W'(a);
  endfunction

  state_t state;

  // Configuration and window bookkeeping
  logic [WSIZE_W-1:0]  window_size;
  logic [CNT_W-1:0]    trim_cap;
  logic [CNT_W-1:0]    fill_count;
  logic [IDX_W-1:0]    oldest_index;
  logic [CNT_W-1:0]    cap;
  logic                cfg_write;

  // Sample and scan datapath
  logic [VAL_W-1:0]    ring [MAX_WINDOW];
  logic [VAL_W-1:0]    rd_data;
  logic                smp_neg;
  logic [VAL_W-1:0]    smp_val;
  logic                smp_acc;
  logic                ring_we;
  logic [IDX_W-1:0]    ring_waddr;
  logic [IDX_W-1:0]    scan_addr;
  logic [CNT_W-1:0]    issue_cnt;
  logic                rd_pending;
  logic [VAL_W-1:0]    win_min;
  logic [VAL_W-1:0]    win_max;

  // Divider
  logic [SUM_W-1:0]    quo;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W:0]      rem_sh;
  logic [DCNT_W-1:0]   div_cnt;

  // Output register
  logic                out_valid;
  logic                out_load;

  assign cap       = eff_size(window_size);
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_WINDOW_SIZE) ? APB_DATA_W'(window_size) : '0;

  assign sample_ch.ready = (state == S_IDLE);
  assign result_ch.valid = out_valid;
  assign out_load        = (state == S_DONE) && (!out_valid || result_ch.ready);

  assign ring_we    = (state == S_INSERT) && !smp_neg && (cap != '0);
  assign ring_waddr = wrap_idx(ADD_W'(oldest_index) + ADD_W'(fill_count));
  assign rem_sh     = {rem, quo[SUM_W-1]};

  // Sequencer and window control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      window_size  <= WINDOW_RESET;
      trim_cap     <= CAP_MAX;
      fill_count   <= '0;
      oldest_index <= '0;
      out_valid    <= 1'b0;
      rd_pending   <= 1'b0;
      issue_cnt    <= '0;
      div_cnt      <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          // Remember the tightest size written since the last sample
          if (cfg_write) begin
            window_size <= pwdata[WSIZE_W-1:0];
            if (eff_size(pwdata[WSIZE_W-1:0]) < trim_cap) begin
              trim_cap <= eff_size(pwdata[WSIZE_W-1:0]);
            end
          end
          if (sample_ch.valid) begin
            state <= S_TRIM;
          end
        end
        S_TRIM: begin
          // Drop the oldest excess samples left by a lowered size
          if (fill_count > trim_cap) begin
            oldest_index <= wrap_idx(ADD_W'(oldest_index) + ADD_W'(fill_count - trim_cap));
            fill_count   <= trim_cap;
          end
          trim_cap <= CAP_MAX;
          state    <= S_INSERT;
        end
        S_INSERT: begin
          // Store the sample, evicting the oldest when full
          if (ring_we) begin
            if (fill_count == cap) begin
              oldest_index <= (oldest_index == IDX_LAST) ? '0 : oldest_index + 1'b1;
            end else begin
              fill_count <= fill_count + 1'b1;
            end
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          issue_cnt  <= '0;
          rd_pending <= 1'b0;
          state      <= (fill_count == '0) ? S_DONE : S_SCAN;
        end
        S_SCAN: begin
          // Issue one ring read per cycle; fold the registered read data while rd_pending is set
          if (issue_cnt != fill_count) begin
            issue_cnt  <= issue_cnt + 1'b1;
            rd_pending <= 1'b1;
          end else begin
            rd_pending <= 1'b0;
            if (!rd_pending) begin
              div_cnt <= DCNT_W'(SUM_W);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCNT_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Ring memory: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_waddr] <= smp_val;
    end
    rd_data <= ring[scan_addr];
  end

  // Payload datapath: sample hold, scan fold, divider, result register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && sample_ch.valid) begin
      smp_neg <= sample_ch.sample[SAMPLE_W-1];
      smp_val <= sample_ch.sample[VAL_W-1:0];
    end
    if (state == S_INSERT) begin
      smp_acc <= ring_we;
    end
    case (state)
      S_LOAD: begin
        scan_addr <= oldest_index;
        quo       <= '0;
        if (fill_count == '0) begin
          win_min <= '0;
        end else begin
          win_min <= '1;
        end
        win_max <= '0;
      end
      S_SCAN: begin
        if (issue_cnt != fill_count) begin
          scan_addr <= (scan_addr == IDX_LAST) ? '0 : scan_addr + 1'b1;
        end
        if (rd_pending) begin
          if (rd_data < win_min) begin
            win_min <= rd_data;
          end
          if (rd_data > win_max) begin
            win_max <= rd_data;
          end
          quo <= quo + SUM_W'(rd_data);
        end
        rem <= '0;
      end
      S_DIV: begin
        // One restoring step: shift in a dividend bit, subtract if it fits
        if (rem_sh >= (CNT_W + 1)'(fill_count)) begin
          rem <= CNT_W'(rem_sh - (CNT_W + 1)'(fill_count));
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= CNT_W'(rem_sh);
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (out_load) begin
      result_ch.held_count  <= COUNT_W'(fill_count);
      result_ch.window_min  <= win_min;
      result_ch.window_max  <= win_max;
      result_ch.window_mean <= quo[VAL_W-1:0];
      result_ch.accepted    <= smp_acc;
    end
  end

endmodule
